@@ rtl/core/lrupr_pkg.sv @@
// lrupr_pkg: shared types and constants of the lru page replacement unit
package lrupr_pkg;

   localparam int MAX_FRAMES_DEF = 16;
   localparam int PAGE_BITS_DEF  = 20;
   localparam int PAGE_W         = PAGE_BITS_DEF;
   localparam int FRAME_CNT_W    = 5;
   localparam int CNT_W          = 32;
   localparam logic [FRAME_CNT_W-1:0] FRAME_CNT_RST = FRAME_CNT_W'(16);
   localparam logic [CNT_W-1:0]       CNT_SAT       = {CNT_W{1'b1}};

   typedef struct packed {
      logic [PAGE_W-1:0] page_number;
      logic              is_write;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic              evicted;
      logic [PAGE_W-1:0] victim_page;
      logic [CNT_W-1:0]  hit_total;
      logic [CNT_W-1:0]  miss_total;
      logic [CNT_W-1:0]  disk_read_total;
      logic [CNT_W-1:0]  disk_write_total;
      logic [CNT_W-1:0]  replace_total;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic hit;
      logic evict;
   } ctl_type;

endpackage

@@ rtl/core/lru_page_replacement_unit.sv @@
// lru_page_replacement_unit: top level of the lru page replacement unit
//
// Takes one memory access word (page number, write flag) on req_data when start
// is high; busy stays low, so a word can be given in every clock cycle.
// In the cycle after an access is taken, rsp_strobe is high for exactly one
// cycle with hit, evicted, victim_page and the five saturating totals as
// they stand after that access. The receiver cannot stall; the result is
// gone after its one cycle.
// Throughput is 1 word per cycle: the recency order lives in a chain of
// MAX_FRAMES cells that all compare the page at once and shift toward the
// tail in the same cycle, with the hit search rippling through the chain.
// csr_we writes frame_count from csr_wdata; it takes effect on the next
// access and is clamped to 2..MAX_FRAMES.
// Reset empties all frames, clears all totals and sets frame_count to 16.
module lru_page_replacement_unit #(
   parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  lrupr_pkg::req_type               req_data,
   output logic                             rsp_strobe,
   output lrupr_pkg::rsp_type               rsp_data,
   input  logic                             csr_we,
   input  logic [lrupr_pkg::FRAME_CNT_W-1:0] csr_wdata
);
   import lrupr_pkg::*;

   localparam int RC_W = $clog2(MAX_FRAMES + 1);

   logic [FRAME_CNT_W-1:0] frame_cnt_ff;
   logic [RC_W-1:0]        rc_ff;
   logic [RC_W-1:0]        rc_in;
   logic [RC_W-1:0]        limit;
   logic                   rsp_strobe_ff;
   logic                   hit_ff;
   logic                   evicted_ff;
   logic [PAGE_W-1:0]      victim_ff;

   ctl_type                ctl;
   logic [PAGE_W-1:0]      page;
   logic [PAGE_W-1:0]      tag_q [MAX_FRAMES];
   logic [MAX_FRAMES-1:0]  dirty_q;
   logic [MAX_FRAMES-1:0]  valid_q;
   logic [MAX_FRAMES-1:0]  match;
   logic [MAX_FRAMES-1:0]  last_vec;
   logic [MAX_FRAMES:0]    seen;
   logic [PAGE_W-1:0]      victim;
   logic                   hit;
   logic                   evict;
   logic                   dirty_hit;
   logic [CNT_W-1:0]       hit_total;
   logic [CNT_W-1:0]       miss_total;
   logic [CNT_W-1:0]       read_total;
   logic [CNT_W-1:0]       write_total;
   logic [CNT_W-1:0]       replace_total;

   assign busy    = 1'b0;
   assign page    = req_data.page_number;
   assign seen[0] = 1'b0;

   always_comb begin
      if (32'(frame_cnt_ff) > 32'(MAX_FRAMES)) begin
         limit = RC_W'(MAX_FRAMES);
      end else if (32'(frame_cnt_ff) < 32'd2) begin
         limit = RC_W'(2);
      end else begin
         limit = RC_W'(frame_cnt_ff);
      end
   end

   always_comb begin
      hit       = seen[MAX_FRAMES];
      evict     = !hit && (rc_ff >= limit);
      dirty_hit = |(match & dirty_q);
      last_vec  = valid_q & ~(valid_q >> 1);
      victim    = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         victim = victim | (tag_q[i] & {PAGE_W{last_vec[i]}});
      end
      ctl.load  = start && !busy;
      ctl.hit   = hit;
      ctl.evict = evict;
      rc_in     = rc_ff;
      if (ctl.load && !hit && !evict) begin
         rc_in = rc_ff + RC_W'(1);
      end
   end

   for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
      logic [PAGE_W-1:0] prev_tag;
      logic              prev_dirty;
      logic              prev_valid;
      if (g == 0) begin : g_head
         assign prev_tag   = page;
         assign prev_dirty = req_data.is_write;
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_tag   = tag_q[g-1];
         assign prev_dirty = dirty_q[g-1];
         assign prev_valid = valid_q[g-1];
      end
      lrupr_cell #(
         .TAG_W (PAGE_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .page       (page),
         .prev_tag   (prev_tag),
         .prev_dirty (prev_dirty),
         .prev_valid (prev_valid),
         .seen_in    (seen[g]),
         .seen_out   (seen[g+1]),
         .match      (match[g]),
         .tag_q      (tag_q[g]),
         .dirty_q    (dirty_q[g]),
         .valid_q    (valid_q[g])
      );
   end

   lrupr_sat_ctr u_hit_ctr (
      .clock (clock), .reset (reset), .inc (ctl.load && hit), .count (hit_total)
   );
   lrupr_sat_ctr u_miss_ctr (
      .clock (clock), .reset (reset), .inc (ctl.load && !hit), .count (miss_total)
   );
   lrupr_sat_ctr u_read_ctr (
      .clock (clock), .reset (reset), .inc (ctl.load && !hit), .count (read_total)
   );
   lrupr_sat_ctr u_write_ctr (
      .clock (clock),
      .reset (reset),
      .inc   (ctl.load && req_data.is_write && !(hit && dirty_hit)),
      .count (write_total)
   );
   lrupr_sat_ctr u_replace_ctr (
      .clock (clock), .reset (reset), .inc (ctl.load && evict), .count (replace_total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cnt_ff  <= FRAME_CNT_RST;
         rc_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            frame_cnt_ff <= csr_wdata;
         end
         rc_ff         <= rc_in;
         rsp_strobe_ff <= ctl.load;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         hit_ff     <= hit;
         evicted_ff <= evict;
         victim_ff  <= evict ? victim : '0;
      end
   end

   always_comb begin
      rsp_strobe                = rsp_strobe_ff;
      rsp_data.hit              = hit_ff;
      rsp_data.evicted          = evicted_ff;
      rsp_data.victim_page      = victim_ff;
      rsp_data.hit_total        = hit_total;
      rsp_data.miss_total       = miss_total;
      rsp_data.disk_read_total  = read_total;
      rsp_data.disk_write_total = write_total;
      rsp_data.replace_total    = replace_total;
   end

endmodule

@@ rtl/core/lrupr_sat_ctr.sv @@
// lrupr_sat_ctr: saturating event counter
module lrupr_sat_ctr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       inc,
   output logic [lrupr_pkg::CNT_W-1:0] count
);
   import lrupr_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (inc && count_ff != CNT_SAT) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

@@ rtl/core/lrupr_cell.sv @@
// lrupr_cell: one recency slot, compares its tag and takes its neighbor's entry on a shift
module lrupr_cell #(
   parameter int TAG_W = lrupr_pkg::PAGE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  lrupr_pkg::ctl_type  ctl,
   input  logic [TAG_W-1:0]    page,
   input  logic [TAG_W-1:0]    prev_tag,
   input  logic                prev_dirty,
   input  logic                prev_valid,
   input  logic                seen_in,
   output logic                seen_out,
   output logic                match,
   output logic [TAG_W-1:0]    tag_q,
   output logic                dirty_q,
   output logic                valid_q
);
   import lrupr_pkg::*;

   logic [TAG_W-1:0] tag_ff;
   logic [TAG_W-1:0] tag_in;
   logic             dirty_ff;
   logic             dirty_in;
   logic             valid_ff;
   logic             valid_in;
   logic             shift;

   always_comb begin
      match    = valid_ff && (tag_ff == page);
      seen_out = seen_in | match;
      if (ctl.hit) begin
         shift = ctl.load && !seen_in;
      end else if (ctl.evict) begin
         shift = ctl.load && valid_ff;
      end else begin
         shift = ctl.load && prev_valid;
      end
      tag_in   = shift ? prev_tag   : tag_ff;
      dirty_in = shift ? prev_dirty : dirty_ff;
      valid_in = shift ? prev_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         dirty_ff <= dirty_in;
         valid_ff <= valid_in;
      end
   end

   assign tag_q   = tag_ff;
   assign dirty_q = dirty_ff;
   assign valid_q = valid_ff;

endmodule

@@ rtl/core/lrupr_checker.sv @@
// lrupr_checker: port-level assertions for the lru page replacement unit, bound to the top level
module lrupr_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input lrupr_pkg::rsp_type rsp_data
);
   import lrupr_pkg::*;

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_strobe)
      else $error("no result word one cycle after an accepted access");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("result word without an accepted access");

   a_evict_is_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.evicted |-> !rsp_data.hit)
      else $error("eviction reported on a hit");

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.evicted |-> rsp_data.victim_page == '0)
      else $error("victim page set without an eviction");

   a_read_per_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.miss_total == rsp_data.disk_read_total)
      else $error("disk read total differs from miss total");

endmodule

bind lru_page_replacement_unit lrupr_checker u_lrupr_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

@@ tb/tb_lru_page_replacement_unit.sv @@
// tb_lru_page_replacement_unit: self-checking testbench of the lru page replacement unit
`timescale 1ns / 1ps

module tb_lru_page_replacement_unit;
   import lrupr_pkg::*;

   localparam int FRAMES = MAX_FRAMES_DEF;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_WORDS = 130;
   localparam int REPORT_LIMIT = 10;

   typedef enum logic {ROW_ACCESS, ROW_FRAMES} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [PAGE_W-1:0] value;
      logic              wr;
      bit                typed;
      rsp_type           want;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [FRAME_CNT_W-1:0] csr_wdata;

   // predictor state
   logic [PAGE_W-1:0]      tag_order [FRAMES];
   logic                   dirty_order [FRAMES];
   int                     resident_pages;
   logic [CNT_W-1:0]       hits_seen, misses_seen, reads_seen, writes_seen, evictions_seen;
   logic [FRAME_CNT_W-1:0] frame_setting;

   rsp_type      pending_outcomes [$];
   stim_row_type access_table [$];
   int           mismatches;
   int           words_sent;
   int           hit_results;
   int           evict_results;
   int           frame_writes;
   bit           gaps_on;

   lru_page_replacement_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_SAT) ? v : v + CNT_W'(1);
   endfunction

   function automatic rsp_type outcome(input logic h, input logic e, input logic [PAGE_W-1:0] v,
                                       input int ht, input int mt, input int rt,
                                       input int wt, input int pt);
      rsp_type o;
      o.hit = h;
      o.evicted = e;
      o.victim_page = v;
      o.hit_total = CNT_W'(ht);
      o.miss_total = CNT_W'(mt);
      o.disk_read_total = CNT_W'(rt);
      o.disk_write_total = CNT_W'(wt);
      o.replace_total = CNT_W'(pt);
      return o;
   endfunction

   // lru lookup and update for one access, returns the result it should produce
   function automatic rsp_type replace_page(input req_type r);
      int      limit;
      int      found;
      int      depth;
      int      i;
      rsp_type o;
      o = '0;
      limit = int'(frame_setting);
      if (limit < 2) limit = 2;
      if (limit > FRAMES) limit = FRAMES;
      found = -1;
      for (i = 0; i < resident_pages && i < FRAMES; i++)
         if (found < 0 && tag_order[i] == r.page_number) found = i;
      if (found >= 0) begin
         if (!dirty_order[found] && r.is_write) writes_seen = sat_inc(writes_seen);
         hits_seen = sat_inc(hits_seen);
         o.hit = 1'b1;
         depth = found;
      end else begin
         misses_seen = sat_inc(misses_seen);
         reads_seen = sat_inc(reads_seen);
         if (r.is_write) writes_seen = sat_inc(writes_seen);
         if (resident_pages < limit) begin
            depth = resident_pages;
            resident_pages++;
         end else begin
            depth = resident_pages - 1;
            if (depth >= FRAMES) depth = FRAMES - 1;
            o.evicted = 1'b1;
            o.victim_page = tag_order[depth];
            evictions_seen = sat_inc(evictions_seen);
         end
      end
      for (i = depth; i > 0; i--) begin
         if (i < FRAMES) begin
            tag_order[i] = tag_order[i-1];
            dirty_order[i] = dirty_order[i-1];
         end
      end
      tag_order[0] = r.page_number;
      dirty_order[0] = r.is_write;
      o.hit_total = hits_seen;
      o.miss_total = misses_seen;
      o.disk_read_total = reads_seen;
      o.disk_write_total = writes_seen;
      o.replace_total = evictions_seen;
      return o;
   endfunction

   // called just after a falling edge, returns just after a falling edge
   task automatic drive_access(input logic [PAGE_W-1:0] page, input logic wr,
                               input bit typed, input rsp_type want);
      req_type r;
      rsp_type predicted;
      r.page_number = page;
      r.is_write = wr;
      while (gaps_on && $urandom_range(99) < 22) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predicted = replace_page(r);
      pending_outcomes.push_back(typed ? want : predicted);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic write_frames(input logic [FRAME_CNT_W-1:0] v);
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      frame_setting = v;
      frame_writes++;
   endtask

   task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                              input logic [CNT_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("mismatch %s: expected %h, got %h at %0t", name, want, got, $realtime);
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (rsp_data.hit === 1'b1) hit_results++;
         if (rsp_data.evicted === 1'b1) evict_results++;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result word with nothing pending at %0t", $realtime);
         end else begin
            want = pending_outcomes.pop_front();
            check_field("hit", CNT_W'(want.hit), CNT_W'(rsp_data.hit));
            check_field("evicted", CNT_W'(want.evicted), CNT_W'(rsp_data.evicted));
            check_field("victim_page", CNT_W'(want.victim_page),
                        CNT_W'(rsp_data.victim_page));
            check_field("hit_total", want.hit_total, rsp_data.hit_total);
            check_field("miss_total", want.miss_total, rsp_data.miss_total);
            check_field("disk_read_total", want.disk_read_total, rsp_data.disk_read_total);
            check_field("disk_write_total", want.disk_write_total, rsp_data.disk_write_total);
            check_field("replace_total", want.replace_total, rsp_data.replace_total);
         end
      end
   end

   task automatic add_row(input row_kind_type kind, input logic [PAGE_W-1:0] value,
                          input logic wr, input bit typed, input rsp_type want);
      stim_row_type row;
      row.kind = kind;
      row.value = value;
      row.wr = wr;
      row.typed = typed;
      row.want = want;
      access_table.push_back(row);
   endtask

   initial begin : stimulus
      logic [PAGE_W-1:0] page_pool [32];
      logic [FRAME_CNT_W-1:0] phase_frames;
      int pool_size;
      int p;
      int k;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      mismatches = 0;
      words_sent = 0;
      hit_results = 0;
      evict_results = 0;
      frame_writes = 0;
      gaps_on = 1'b1;
      resident_pages = 0;
      hits_seen = '0;
      misses_seen = '0;
      reads_seen = '0;
      writes_seen = '0;
      evictions_seen = '0;
      frame_setting = FRAME_CNT_RST;
      for (k = 0; k < FRAMES; k++) begin
         tag_order[k] = '0;
         dirty_order[k] = 1'b0;
      end

      // empty frames, hits on clean and dirty pages, then a two frame limit
      add_row(ROW_ACCESS, 20'h00000, 1'b0, 1'b1,
              outcome(1'b0, 1'b0, 20'h0, 0, 1, 1, 0, 0));
      add_row(ROW_ACCESS, 20'hFFFFF, 1'b1, 1'b1,
              outcome(1'b0, 1'b0, 20'h0, 0, 2, 2, 1, 0));
      add_row(ROW_ACCESS, 20'h00000, 1'b1, 1'b1,
              outcome(1'b1, 1'b0, 20'h0, 1, 2, 2, 2, 0));
      add_row(ROW_ACCESS, 20'h00000, 1'b1, 1'b1,
              outcome(1'b1, 1'b0, 20'h0, 2, 2, 2, 2, 0));
      add_row(ROW_ACCESS, 20'hFFFFF, 1'b0, 1'b1,
              outcome(1'b1, 1'b0, 20'h0, 3, 2, 2, 2, 0));
      add_row(ROW_FRAMES, 20'd0, 1'b0, 1'b0, '0);
      add_row(ROW_ACCESS, 20'h12345, 1'b0, 1'b1,
              outcome(1'b0, 1'b1, 20'h00000, 3, 3, 3, 2, 1));
      add_row(ROW_ACCESS, 20'hAAAAA, 1'b1, 1'b1,
              outcome(1'b0, 1'b1, 20'hFFFFF, 3, 4, 4, 3, 2));
      add_row(ROW_ACCESS, 20'h55555, 1'b0, 1'b1,
              outcome(1'b0, 1'b1, 20'h12345, 3, 5, 5, 3, 3));
      // above the built depth, fill all frames and evict from the tail
      add_row(ROW_FRAMES, 20'd17, 1'b0, 1'b0, '0);
      for (k = 1; k <= 15; k++) add_row(ROW_ACCESS, PAGE_W'(k), k[0], 1'b0, '0);
      // limit lowered under residency: deep pages still hit, misses evict the tail
      add_row(ROW_FRAMES, 20'd3, 1'b0, 1'b0, '0);
      add_row(ROW_ACCESS, 20'h55555, 1'b1, 1'b0, '0);
      add_row(ROW_ACCESS, 20'h80000, 1'b0, 1'b0, '0);
      add_row(ROW_FRAMES, 20'd1, 1'b0, 1'b0, '0);
      add_row(ROW_ACCESS, 20'h7FFFF, 1'b1, 1'b0, '0);

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (access_table[i]) begin
         if (access_table[i].kind == ROW_FRAMES)
            write_frames(access_table[i].value[FRAME_CNT_W-1:0]);
         else
            drive_access(access_table[i].value, access_table[i].wr,
                         access_table[i].typed, access_table[i].want);
      end

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               phase_frames = 5'd2;
            end
            1: begin
               phase_frames = 5'd16;
            end
            2: begin
               phase_frames = 5'd31;
            end
            3: begin
               phase_frames = 5'd0;
            end
            default: begin
               phase_frames = FRAME_CNT_W'($urandom_range(31));
            end
         endcase
         write_frames(phase_frames);
         // a working set of 1 to 24 pages, used for most accesses, keeps hits and evictions coming
         pool_size = $urandom_range(1, 24);
         for (k = 0; k < pool_size; k++)
            page_pool[k] = ($urandom_range(1)) ? PAGE_W'($urandom) : PAGE_W'($urandom_range(40));
         gaps_on = !(p == 4 || p == 5);
         for (k = 0; k < PHASE_WORDS; k++) begin
            if ($urandom_range(99) < 85)
               drive_access(page_pool[$urandom_range(pool_size - 1)], 1'($urandom_range(1)),
                            1'b0, '0);
            else
               drive_access(PAGE_W'($urandom), 1'($urandom_range(1)), 1'b0, '0);
         end
      end
      start <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("sent %0d access words over %0d frame limit settings", words_sent, frame_writes);
      $display("results with a hit: %0d, with an eviction: %0d", hit_results, evict_results);
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_outcomes.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
